### hw/rtl/rsfs_pkg.sv
// ----------------------------------------------------------------------------
// rsfs_pkg
// Shared types, codes and constants of the slot fair scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package rsfs_pkg;

	localparam int IDX_W = 3;                 // index fields, counts are at most 8
	localparam int DIV_NW = 48;               // divider dividend / quotient width
	localparam int DIV_DW = 16;               // divider divisor / remainder width
	localparam int DIV_CW = 6;                // divider step counter width

	localparam logic [3:0]  NO_TASK    = 4'd15;
	localparam logic [3:0]  NEVER_TASK = 4'd14;
	localparam logic [26:0] DEV_MAX    = 27'h7FFFFFF;
	localparam logic [31:0] SEED_RESET = 32'd5;
	localparam int XS_A = 13;
	localparam int XS_B = 17;
	localparam int XS_C = 5;

	localparam logic [63:0] SLOT_SIZES_RST  = 64'h0;
	localparam logic [63:0] DEMANDS_RST     = 64'h0;
	localparam logic [63:0] LATENCIES_RST   = 64'h0101010101010101;
	localparam logic [15:0] QUANTUM_RST     = 16'd1;
	localparam logic        SHUFFLE_RST     = 1'b0;
	localparam logic [23:0] TARGET_RST      = 24'h010000;

	typedef enum logic [2:0] {
		CFG_SLOT_SIZES     = 3'd0,
		CFG_TASK_DEMANDS   = 3'd1,
		CFG_TASK_LATENCIES = 3'd2,
		CFG_QUANTUM        = 3'd3,
		CFG_SHUFFLE_ENABLE = 3'd4,
		CFG_TARGET_SHARE   = 3'd5
	} cfg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_XS,
		ST_MOD,
		ST_QSTART,
		ST_QWAIT,
		ST_FREE,
		ST_SINIT,
		ST_SCAN,
		ST_COMMIT,
		ST_BINC,
		ST_RUN,
		ST_RECFG,
		ST_MUL1,
		ST_MUL2,
		ST_DSTART,
		ST_DWAIT,
		ST_ACC,
		ST_OUT
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LATCH,
		OP_XS,
		OP_MODB,
		OP_QDIV,
		OP_FREE,
		OP_SINIT,
		OP_SCAN,
		OP_COMMIT,
		OP_BINC,
		OP_RUN,
		OP_RECFG,
		OP_MUL1,
		OP_MUL2,
		OP_DDIV,
		OP_ACC,
		OP_OUT
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] k;        // task / visit position
		logic [IDX_W-1:0] j;        // slot
		logic [1:0]       b;        // seed byte, most significant first
	} cmd_t;

	typedef struct packed {
		logic div_busy;
		logic boundary;
		logic last;
		logic rate_zero;
		logic out_free;
		logic shuffle_en;
	} stat_t;

	function automatic logic [7:0] byte_of(input logic [63:0] r, input logic [IDX_W-1:0] i);
		byte_of = r[8*i +: 8];
	endfunction

endpackage

`default_nettype wire

### hw/rtl/rsfs_ifs.sv
// ----------------------------------------------------------------------------
// rsfs channel interfaces
// Tick request, result and configuration write channels, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface rsfs_req_if;
	logic valid;
	logic ready;
	logic last_tick;
	modport source (output valid, output last_tick, input ready);
	modport sink   (input valid, input last_tick, output ready);
endinterface

interface rsfs_res_if;
	logic        valid;
	logic        ready;
	logic [31:0] slot_occupants;
	logic [15:0] tick_number;
	logic [19:0] reconfig_total;
	logic        frame_done;
	logic [26:0] deviation_sum;
	modport source (output valid, output slot_occupants, output tick_number,
		output reconfig_total, output frame_done, output deviation_sum, input ready);
	modport sink   (input valid, input slot_occupants, input tick_number,
		input reconfig_total, input frame_done, input deviation_sum, output ready);
endinterface

interface rsfs_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [63:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/reconfig_slot_fair_scheduler_top.sv
// ----------------------------------------------------------------------------
// reconfig_slot_fair_scheduler_top
// Fair scheduler of tasks onto reconfigurable slots, one request per tick.
// ----------------------------------------------------------------------------
// Usage:
//  - cfg: register writes (index 0..5: slot sizes, demands, latencies,
//    quantum, shuffle enable, target share). Always ready; write only while
//    no tick request is in flight. Indexes 6 and 7 are ignored.
//  - req: one request per tick, carrying last_tick. Accepted only while the
//    sequencer is idle; one request is worked on at a time.
//  - res: one result per request from an output register. A request may be
//    accepted while the previous result still waits; a stalled receiver
//    holds the next result in the sequencer until the register frees.
//  - Tick sequence: a plain tick runs the boundary test and the run pass;
//    shuffle adds 8 tasks x (xorshift + 4 byte-wise modulo steps); on a
//    quantum boundary the free pass, 8 tasks x (slot scan and commit) and
//    the elapsed step replace the run pass. The 48-step shared divider
//    sets the boundary test (tick mod quantum) and, on the frame's last
//    tick, the per-task rate division for the deviation report (skipped
//    while no rate tick is recorded).
//  - Reset (arst_n low) restores all registers and scheduler state; the
//    state also returns to reset after every last-tick result.
// ----------------------------------------------------------------------------
`default_nettype none

module reconfig_slot_fair_scheduler_top #(
	parameter int SLOT_COUNT = 8,
	parameter int TASK_COUNT = 8
) (
	input wire logic  clk,
	input wire logic  arst_n,
	rsfs_req_if.sink  req,
	rsfs_res_if.source res,
	rsfs_cfg_if.sink  cfg
);

	rsfs_pkg::cmd_t  cmd;    // sequencer -> datapath
	rsfs_pkg::stat_t stat;   // datapath -> sequencer

	assign cfg.ready = 1'b1;

	rsfs_ctrl #(
		.SLOT_COUNT (SLOT_COUNT),
		.TASK_COUNT (TASK_COUNT)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	rsfs_dp #(
		.SLOT_COUNT (SLOT_COUNT),
		.TASK_COUNT (TASK_COUNT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg.valid),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.req_last  (req.last_tick),
		.cmd       (cmd),
		.stat      (stat),
		.res_ready (res.ready),
		.res_valid (res.valid),
		.res_occ   (res.slot_occupants),
		.res_tick  (res.tick_number),
		.res_total (res.reconfig_total),
		.res_done  (res.frame_done),
		.res_dev   (res.deviation_sum)
	);

endmodule

`default_nettype wire

### hw/rtl/rsfs_div.sv
// ----------------------------------------------------------------------------
// rsfs_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rsfs_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [rsfs_pkg::DIV_NW-1:0]  dividend,
	input  wire logic [rsfs_pkg::DIV_DW-1:0]  divisor,
	output logic                              busy,
	output logic      [rsfs_pkg::DIV_NW-1:0]  quotient,
	output logic      [rsfs_pkg::DIV_DW-1:0]  remainder
);

	logic                          busy_q;
	logic [rsfs_pkg::DIV_CW-1:0]   cnt_q;
	logic [rsfs_pkg::DIV_NW-1:0]   quo_q;
	logic [rsfs_pkg::DIV_DW-1:0]   rem_q;
	logic [rsfs_pkg::DIV_DW-1:0]   div_q;
	logic [rsfs_pkg::DIV_DW:0]     trial;
	logic                          fits;

	assign trial = {rem_q, quo_q[rsfs_pkg::DIV_NW-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= rsfs_pkg::DIV_CW'(rsfs_pkg::DIV_NW - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) busy_q <= 1'b0;
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[rsfs_pkg::DIV_NW-2:0], fits};
			rem_q <= fits ? rsfs_pkg::DIV_DW'(trial - {1'b0, div_q})
			              : rsfs_pkg::DIV_DW'(trial);
		end
	end

	assign busy      = busy_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

### hw/rtl/rsfs_ctrl.sv
// ----------------------------------------------------------------------------
// rsfs_ctrl
// Sequencer: walks shuffle, boundary test, scheduling, run counting, report.
// ----------------------------------------------------------------------------
`default_nettype none

module rsfs_ctrl #(
	parameter int SLOT_COUNT = 8,
	parameter int TASK_COUNT = 8
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_ready,
	input  wire rsfs_pkg::stat_t stat,
	output rsfs_pkg::cmd_t       cmd
);

	localparam logic [rsfs_pkg::IDX_W-1:0] J_LAST = rsfs_pkg::IDX_W'(SLOT_COUNT - 1);
	localparam logic [rsfs_pkg::IDX_W-1:0] K_LAST = rsfs_pkg::IDX_W'(TASK_COUNT - 1);

	rsfs_pkg::state_t              state_q, state_d;
	logic [rsfs_pkg::IDX_W-1:0]    k_q, k_d, j_q, j_d;
	logic [1:0]                    b_q, b_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rsfs_pkg::ST_IDLE;
			k_q     <= '0;
			j_q     <= '0;
			b_q     <= '0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			j_q     <= j_d;
			b_q     <= b_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		k_d       = k_q;
		j_d       = j_q;
		b_d       = b_q;
		req_ready = 1'b0;
		cmd.op    = rsfs_pkg::OP_NONE;
		cmd.k     = k_q;
		cmd.j     = j_q;
		cmd.b     = b_q;
		case (state_q)
			rsfs_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.op  = rsfs_pkg::OP_LATCH;
					k_d     = '0;
					state_d = stat.shuffle_en ? rsfs_pkg::ST_XS : rsfs_pkg::ST_QSTART;
				end
			end
			rsfs_pkg::ST_XS: begin
				cmd.op  = rsfs_pkg::OP_XS;
				b_d     = '0;
				state_d = rsfs_pkg::ST_MOD;
			end
			rsfs_pkg::ST_MOD: begin
				cmd.op = rsfs_pkg::OP_MODB;
				b_d    = b_q + 1'b1;
				if (b_q == 2'd3) begin
					if (k_q == K_LAST) begin
						k_d     = '0;
						state_d = rsfs_pkg::ST_QSTART;
					end else begin
						k_d     = k_q + 1'b1;
						state_d = rsfs_pkg::ST_XS;
					end
				end
			end
			rsfs_pkg::ST_QSTART: begin
				cmd.op  = rsfs_pkg::OP_QDIV;
				state_d = rsfs_pkg::ST_QWAIT;
			end
			rsfs_pkg::ST_QWAIT: begin
				if (!stat.div_busy) begin
					j_d     = '0;
					state_d = stat.boundary ? rsfs_pkg::ST_FREE : rsfs_pkg::ST_RUN;
				end
			end
			rsfs_pkg::ST_FREE: begin
				cmd.op  = rsfs_pkg::OP_FREE;
				k_d     = '0;
				state_d = rsfs_pkg::ST_SINIT;
			end
			rsfs_pkg::ST_SINIT: begin
				cmd.op  = rsfs_pkg::OP_SINIT;
				j_d     = '0;
				state_d = rsfs_pkg::ST_SCAN;
			end
			rsfs_pkg::ST_SCAN: begin
				cmd.op = rsfs_pkg::OP_SCAN;
				if (j_q == J_LAST) state_d = rsfs_pkg::ST_COMMIT;
				else               j_d     = j_q + 1'b1;
			end
			rsfs_pkg::ST_COMMIT: begin
				cmd.op = rsfs_pkg::OP_COMMIT;
				if (k_q == K_LAST) begin
					state_d = rsfs_pkg::ST_BINC;
				end else begin
					k_d     = k_q + 1'b1;
					state_d = rsfs_pkg::ST_SINIT;
				end
			end
			rsfs_pkg::ST_BINC: begin
				cmd.op  = rsfs_pkg::OP_BINC;
				state_d = rsfs_pkg::ST_RECFG;
			end
			rsfs_pkg::ST_RUN: begin
				cmd.op = rsfs_pkg::OP_RUN;
				if (j_q == J_LAST) state_d = rsfs_pkg::ST_RECFG;
				else               j_d     = j_q + 1'b1;
			end
			rsfs_pkg::ST_RECFG: begin
				cmd.op = rsfs_pkg::OP_RECFG;
				k_d    = '0;
				state_d = stat.last ? rsfs_pkg::ST_MUL1 : rsfs_pkg::ST_OUT;
			end
			rsfs_pkg::ST_MUL1: begin
				cmd.op  = rsfs_pkg::OP_MUL1;
				state_d = rsfs_pkg::ST_MUL2;
			end
			rsfs_pkg::ST_MUL2: begin
				cmd.op  = rsfs_pkg::OP_MUL2;
				state_d = stat.rate_zero ? rsfs_pkg::ST_ACC : rsfs_pkg::ST_DSTART;
			end
			rsfs_pkg::ST_DSTART: begin
				cmd.op  = rsfs_pkg::OP_DDIV;
				state_d = rsfs_pkg::ST_DWAIT;
			end
			rsfs_pkg::ST_DWAIT: begin
				if (!stat.div_busy) state_d = rsfs_pkg::ST_ACC;
			end
			rsfs_pkg::ST_ACC: begin
				cmd.op = rsfs_pkg::OP_ACC;
				if (k_q == K_LAST) begin
					state_d = rsfs_pkg::ST_OUT;
				end else begin
					k_d     = k_q + 1'b1;
					state_d = rsfs_pkg::ST_MUL1;
				end
			end
			rsfs_pkg::ST_OUT: begin
				if (stat.out_free) begin
					cmd.op  = rsfs_pkg::OP_OUT;
					state_d = rsfs_pkg::ST_IDLE;
				end
			end
			default: state_d = rsfs_pkg::ST_IDLE;
		endcase
	end

endmodule

`default_nettype wire

### hw/rtl/rsfs_dp.sv
// ----------------------------------------------------------------------------
// rsfs_dp
// Scheduler datapath: config registers, slot/task state, shared divider,
// deviation accumulator and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rsfs_dp #(
	parameter int SLOT_COUNT = 8,
	parameter int TASK_COUNT = 8
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cfg_valid,
	input  wire logic [2:0]     cfg_index,
	input  wire logic [63:0]    cfg_data,
	input  wire logic           req_last,
	input  wire rsfs_pkg::cmd_t cmd,
	output rsfs_pkg::stat_t     stat,
	input  wire logic           res_ready,
	output logic                res_valid,
	output logic [31:0]         res_occ,
	output logic [15:0]         res_tick,
	output logic [19:0]         res_total,
	output logic                res_done,
	output logic [26:0]         res_dev
);

	localparam int SW = $clog2(SLOT_COUNT);
	localparam int TW = $clog2(TASK_COUNT);
	localparam int IW = rsfs_pkg::IDX_W;

	// configuration
	logic [63:0] sizes_q, demands_q, lats_q;
	logic [15:0] quantum_q;
	logic        shuffle_q;
	logic [23:0] target_q;

	// slot state
	logic        busy_q  [SLOT_COUNT];
	logic [7:0]  run_q   [SLOT_COUNT];
	logic [15:0] el_q    [SLOT_COUNT];
	logic [7:0]  ph_q    [SLOT_COUNT];   // el_q modulo run_q
	logic [31:0] spri_q  [SLOT_COUNT];
	logic [7:0]  cut_q   [SLOT_COUNT];
	logic [3:0]  stask_q [SLOT_COUNT];
	logic [3:0]  sprev_q [SLOT_COUNT];
	logic [15:0] rc_q    [SLOT_COUNT];

	// task state
	logic [31:0] tp_q    [TASK_COUNT];
	logic [15:0] done_q  [TASK_COUNT];
	logic [15:0] snap_q  [TASK_COUNT];
	logic [2:0]  vo_q    [TASK_COUNT];

	logic [31:0] seed_q;
	logic [15:0] tick_q, rtick_q;
	logic [19:0] total_q;
	logic        last_q;
	logic [26:0] dev_q;
	logic [2:0]  rmod_q;

	// scan scratch
	logic [TW-1:0] t_q;
	logic          best_v_q, pre_v_q;
	logic [SW-1:0] best_q, pre_q;
	logic [7:0]    best_sz_q;

	logic [15:0] p1_q;
	logic [31:0] num_q;

	// divider
	logic                        div_start, div_busy;
	logic [rsfs_pkg::DIV_NW-1:0] div_n, div_quo;
	logic [rsfs_pkg::DIV_DW-1:0] div_d, div_rem;

	rsfs_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_n),
		.divisor   (div_d),
		.busy      (div_busy),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	assign div_start = (cmd.op == rsfs_pkg::OP_QDIV) || (cmd.op == rsfs_pkg::OP_DDIV);
	assign div_n = (cmd.op == rsfs_pkg::OP_QDIV) ? {32'd0, tick_q} : {num_q, 16'd0};
	assign div_d = (cmd.op == rsfs_pkg::OP_QDIV) ?
		((quantum_q == '0) ? 16'd1 : quantum_q) : rtick_q;

	// xorshift step and mod-by-count of one seed byte
	logic [31:0] xs1, xs2, xs3;
	logic [7:0]  sbyte;
	logic [2:0]  rmod_n;

	assign xs1 = seed_q ^ (seed_q << rsfs_pkg::XS_A);
	assign xs2 = xs1 ^ (xs1 >> rsfs_pkg::XS_B);
	assign xs3 = xs2 ^ (xs2 << rsfs_pkg::XS_C);
	assign sbyte = seed_q[8*(3 - cmd.b) +: 8];

	always_comb begin
		logic [3:0] acc;
		rmod_n = (cmd.b == 2'd0) ? 3'd0 : rmod_q;
		for (int i = 7; i >= 0; i--) begin
			acc = {rmod_n, sbyte[i]};
			if (acc >= 4'(TASK_COUNT)) acc = acc - 4'(TASK_COUNT);
			rmod_n = acc[2:0];
		end
	end

	// scan of one slot against the selected task
	logic [SW-1:0] js;
	logic [7:0]    dem_t, sz_j;
	logic [31:0]   np_j;
	logic          fits_j, free_hit, pre_hit;

	assign js     = cmd.j[SW-1:0];
	assign dem_t  = rsfs_pkg::byte_of(demands_q, IW'(t_q));
	assign sz_j   = rsfs_pkg::byte_of(sizes_q, IW'(js));
	assign fits_j = sz_j >= dem_t;
	assign np_j   = spri_q[js] - {24'd0, cut_q[js]};
	assign free_hit = !busy_q[js] && fits_j && (!best_v_q || best_sz_q > sz_j);
	assign pre_hit  = !pre_v_q && fits_j && ($signed(np_j) > $signed(tp_q[t_q]));

	// commit of the selected task
	logic [SW-1:0] cs;
	logic [3:0]    old_t;
	logic          old_ok;
	logic [31:0]   tp_c [TASK_COUNT];
	logic [31:0]   spri_new;

	assign cs     = best_v_q ? best_q : pre_q;
	assign old_t  = stask_q[cs];
	assign old_ok = !best_v_q && pre_v_q && (old_t < 4'(TASK_COUNT));

	always_comb begin
		for (int i = 0; i < TASK_COUNT; i++) begin
			tp_c[i] = tp_q[i];
			if (old_ok && old_t[TW-1:0] == TW'(i)) tp_c[i] = tp_c[i] - {24'd0, cut_q[cs]};
			if (t_q == TW'(i)) tp_c[i] = tp_c[i] + {24'd0, dem_t};
		end
		spri_new = best_v_q ? tp_c[t_q] : tp_c[t_q] - {24'd0, dem_t};
	end

	// elapsed advance per slot
	logic [15:0] el_n [SLOT_COUNT];
	logic [7:0]  ph_n [SLOT_COUNT];
	logic        hit  [SLOT_COUNT];

	always_comb begin
		for (int j = 0; j < SLOT_COUNT; j++) begin
			el_n[j] = el_q[j] + 16'd1;
			if (el_n[j] == '0)                  ph_n[j] = '0;
			else if (ph_q[j] + 8'd1 == run_q[j]) ph_n[j] = '0;
			else                                  ph_n[j] = ph_q[j] + 8'd1;
			hit[j] = (el_n[j] != '0) && (run_q[j] != '0) && (ph_n[j] == '0);
		end
	end

	// reconfiguration increments
	logic [3:0] rc_inc;
	always_comb begin
		rc_inc = '0;
		for (int j = 0; j < SLOT_COUNT; j++)
			if (sprev_q[j] != stask_q[j] && rc_q[j] != 16'hFFFF) rc_inc = rc_inc + 4'd1;
	end

	// deviation of one task
	logic [47:0] rate, diff;
	logic [26:0] diff_c;
	logic [27:0] dsum;

	assign rate   = stat.rate_zero ? 48'd0 : div_quo;
	assign diff   = (rate >= {24'd0, target_q}) ? rate - {24'd0, target_q}
	                                             : {24'd0, target_q} - rate;
	assign diff_c = (diff > {21'd0, rsfs_pkg::DEV_MAX}) ? rsfs_pkg::DEV_MAX : diff[26:0];
	assign dsum   = {1'b0, dev_q} + {1'b0, diff_c};

	logic [31:0] occ;
	for (genvar g = 0; g < 8; g++) begin : g_occ
		if (g < SLOT_COUNT) begin : g_slot
			assign occ[4*g +: 4] = stask_q[g];
		end else begin : g_none
			assign occ[4*g +: 4] = rsfs_pkg::NO_TASK;
		end
	end

	logic [TW-1:0] ks, rtask;
	assign ks    = cmd.k[TW-1:0];
	assign rtask = stask_q[js][TW-1:0];

	// configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sizes_q   <= rsfs_pkg::SLOT_SIZES_RST;
			demands_q <= rsfs_pkg::DEMANDS_RST;
			lats_q    <= rsfs_pkg::LATENCIES_RST;
			quantum_q <= rsfs_pkg::QUANTUM_RST;
			shuffle_q <= rsfs_pkg::SHUFFLE_RST;
			target_q  <= rsfs_pkg::TARGET_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				rsfs_pkg::CFG_SLOT_SIZES:     sizes_q   <= cfg_data;
				rsfs_pkg::CFG_TASK_DEMANDS:   demands_q <= cfg_data;
				rsfs_pkg::CFG_TASK_LATENCIES: lats_q    <= cfg_data;
				rsfs_pkg::CFG_QUANTUM:        quantum_q <= cfg_data[15:0];
				rsfs_pkg::CFG_SHUFFLE_ENABLE: shuffle_q <= cfg_data[0];
				rsfs_pkg::CFG_TARGET_SHARE:   target_q  <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	// result valid: set on output, cleared when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)                         res_valid <= 1'b0;
		else if (cmd.op == rsfs_pkg::OP_OUT) res_valid <= 1'b1;
		else if (res_ready)                  res_valid <= 1'b0;
	end

	// scheduler state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < SLOT_COUNT; j++) begin
				busy_q[j] <= 1'b0;  run_q[j] <= '0;  el_q[j] <= '0;  ph_q[j] <= '0;
				spri_q[j] <= '0;    cut_q[j] <= '0;  rc_q[j] <= '0;
				stask_q[j] <= rsfs_pkg::NO_TASK;
				sprev_q[j] <= rsfs_pkg::NEVER_TASK;
			end
			for (int i = 0; i < TASK_COUNT; i++) begin
				tp_q[i] <= '0;  done_q[i] <= '0;  snap_q[i] <= '0;
				vo_q[i] <= 3'(i);
			end
			seed_q    <= rsfs_pkg::SEED_RESET;
			tick_q    <= '0;
			rtick_q   <= '0;
			total_q   <= '0;
			last_q    <= 1'b0;
			dev_q     <= '0;
			rmod_q    <= '0;
			best_v_q  <= 1'b0;
			pre_v_q   <= 1'b0;
		end else begin
			case (cmd.op)
				rsfs_pkg::OP_LATCH: begin
					last_q <= req_last;
					dev_q  <= '0;
				end
				rsfs_pkg::OP_XS: seed_q <= xs3;
				rsfs_pkg::OP_MODB: begin
					rmod_q <= rmod_n;
					if (cmd.b == 2'd3) vo_q[ks] <= rmod_n;
				end
				rsfs_pkg::OP_FREE: begin
					for (int j = 0; j < SLOT_COUNT; j++) begin
						if (busy_q[j] && el_q[j] != '0) begin
							busy_q[j] <= 1'b0;  run_q[j] <= '0;  el_q[j] <= '0;
							ph_q[j] <= '0;  spri_q[j] <= '0;  cut_q[j] <= '0;
							sprev_q[j] <= stask_q[j];
							stask_q[j] <= rsfs_pkg::NO_TASK;
						end
					end
				end
				rsfs_pkg::OP_SINIT: begin
					t_q      <= vo_q[ks][TW-1:0];
					best_v_q <= 1'b0;
					pre_v_q  <= 1'b0;
				end
				rsfs_pkg::OP_SCAN: begin
					if (free_hit) begin
						best_v_q  <= 1'b1;
						best_q    <= js;
						best_sz_q <= sz_j;
					end
					if (pre_hit) begin
						pre_v_q <= 1'b1;
						pre_q   <= js;
					end
				end
				rsfs_pkg::OP_COMMIT: begin
					if (best_v_q || pre_v_q) begin
						busy_q[cs]  <= 1'b1;
						run_q[cs]   <= rsfs_pkg::byte_of(lats_q, IW'(t_q));
						el_q[cs]    <= '0;
						ph_q[cs]    <= '0;
						stask_q[cs] <= 4'(t_q);
						cut_q[cs]   <= dem_t;
						spri_q[cs]  <= spri_new;
						for (int i = 0; i < TASK_COUNT; i++) tp_q[i] <= tp_c[i];
					end
				end
				rsfs_pkg::OP_BINC: begin
					for (int j = 0; j < SLOT_COUNT; j++) begin
						if (busy_q[j]) begin
							el_q[j] <= el_n[j];
							ph_q[j] <= ph_n[j];
						end
					end
					rtick_q <= tick_q;
					for (int i = 0; i < TASK_COUNT; i++) snap_q[i] <= done_q[i];
				end
				rsfs_pkg::OP_RUN: begin
					if (busy_q[js]) begin
						el_q[js] <= el_n[js];
						ph_q[js] <= ph_n[js];
						if (hit[js] && stask_q[js] < 4'(TASK_COUNT) &&
						    done_q[rtask] != 16'hFFFF)
							done_q[rtask] <= done_q[rtask] + 16'd1;
					end
				end
				rsfs_pkg::OP_RECFG: begin
					for (int j = 0; j < SLOT_COUNT; j++) begin
						if (sprev_q[j] != stask_q[j]) begin
							if (rc_q[j] != 16'hFFFF) rc_q[j] <= rc_q[j] + 16'd1;
							sprev_q[j] <= stask_q[j];
						end
					end
					total_q <= total_q + 20'(rc_inc);
				end
				rsfs_pkg::OP_MUL1:
					p1_q <= {8'd0, rsfs_pkg::byte_of(demands_q, IW'(ks))} *
					        {8'd0, rsfs_pkg::byte_of(lats_q, IW'(ks))};
				rsfs_pkg::OP_MUL2: num_q <= {16'd0, p1_q} * {16'd0, snap_q[ks]};
				rsfs_pkg::OP_ACC:
					dev_q <= (dsum > {1'b0, rsfs_pkg::DEV_MAX}) ? rsfs_pkg::DEV_MAX : dsum[26:0];
				rsfs_pkg::OP_OUT: begin
					res_occ   <= occ;
					res_tick  <= tick_q;
					res_total <= total_q;
					res_done  <= last_q;
					res_dev   <= last_q ? dev_q : '0;
					if (last_q) begin
						for (int j = 0; j < SLOT_COUNT; j++) begin
							busy_q[j] <= 1'b0;  run_q[j] <= '0;  el_q[j] <= '0;
							ph_q[j] <= '0;  spri_q[j] <= '0;  cut_q[j] <= '0;
							rc_q[j] <= '0;
							stask_q[j] <= rsfs_pkg::NO_TASK;
							sprev_q[j] <= rsfs_pkg::NEVER_TASK;
						end
						for (int i = 0; i < TASK_COUNT; i++) begin
							tp_q[i] <= '0;  done_q[i] <= '0;  snap_q[i] <= '0;
							vo_q[i] <= 3'(i);
						end
						seed_q  <= rsfs_pkg::SEED_RESET;
						tick_q  <= '0;
						rtick_q <= '0;
						total_q <= '0;
					end else begin
						tick_q  <= tick_q + 16'd1;
					end
				end
				default: ;
			endcase
		end
	end

	assign stat.div_busy   = div_busy;
	assign stat.boundary   = (div_rem == '0);
	assign stat.last       = last_q;
	assign stat.rate_zero  = (rtick_q == '0);
	assign stat.out_free   = !res_valid || res_ready;
	assign stat.shuffle_en = shuffle_q;

endmodule

`default_nettype wire

### hw/rtl/rsfs_checker.sv
// ----------------------------------------------------------------------------
// rsfs_checker
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rsfs_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        req_valid,
	input wire logic        req_ready,
	input wire logic        res_valid,
	input wire logic        res_ready,
	input wire logic [31:0] slot_occupants,
	input wire logic [15:0] tick_number,
	input wire logic [19:0] reconfig_total,
	input wire logic        frame_done,
	input wire logic [26:0] deviation_sum
);

	// one request at a time
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while previous one in flight");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(tick_number) &&
		$stable(slot_occupants))
		else $error("stalled result changed");

	a_dev_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !frame_done |-> deviation_sum == 27'd0)
		else $error("deviation on non-final result");

	// eight saturating 16-bit counters bound the total
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> reconfig_total <= 20'd524280)
		else $error("reconfiguration total out of range");

endmodule

bind reconfig_slot_fair_scheduler_top rsfs_checker u_rsfs_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.res_valid      (res.valid),
	.res_ready      (res.ready),
	.slot_occupants (res.slot_occupants),
	.tick_number    (res.tick_number),
	.reconfig_total (res.reconfig_total),
	.frame_done     (res.frame_done),
	.deviation_sum  (res.deviation_sum)
);

`default_nettype wire

### tb/sv/rsfs_checker.sv
// ----------------------------------------------------------------------------
// rsfs_tb_checker
// Watches the tick, result and register channels of the slot scheduler,
// predicts each tick's result from its own scheduler model and compares it.
// ----------------------------------------------------------------------------
`default_nettype none

module rsfs_tb_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	rsfs_req_if       req,
	rsfs_res_if       res,
	rsfs_cfg_if       cfg,
	output int        errors,
	output int        pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [31:0] occupants;
		logic [15:0] tick;
		logic [19:0] reconfigs;
		logic        done;
		logic [26:0] deviation;
	} tick_result_t;

	tick_result_t due_q[$];

	// register copies
	logic [63:0] sizes, demands, latencies;
	logic [15:0] quantum;
	logic        shuffle;
	logic [23:0] target;

	// scheduler copy
	logic        s_busy [8];
	logic [7:0]  s_len  [8];
	logic [15:0] s_elap [8];
	logic [31:0] s_pri  [8];
	logic [7:0]  s_cut  [8];
	logic [3:0]  s_task [8];
	logic [3:0]  s_prev [8];
	logic [15:0] s_recf [8];
	logic [31:0] t_pri  [8];
	logic [15:0] t_done [8];
	logic [15:0] t_snap [8];
	logic [2:0]  order  [8];
	logic [31:0] seed;
	logic [15:0] tick_cnt, rate_tick;

	function automatic void clear_sched();
		for (int j = 0; j < 8; j++) begin
			s_busy[j] = 0; s_len[j] = 0; s_elap[j] = 0; s_pri[j] = 0; s_cut[j] = 0;
			s_task[j] = rsfs_pkg::NO_TASK; s_prev[j] = rsfs_pkg::NEVER_TASK; s_recf[j] = 0;
			t_pri[j] = 0; t_done[j] = 0; t_snap[j] = 0; order[j] = 3'(j);
		end
		seed = rsfs_pkg::SEED_RESET;
		tick_cnt = 0;
		rate_tick = 0;
	endfunction

	function automatic void load_slot(int s, int t);
		s_busy[s] = 1;
		s_len[s]  = latencies[8*t +: 8];
		s_elap[s] = 0;
		s_task[s] = 4'(t);
		s_cut[s]  = demands[8*t +: 8];
	endfunction

	function automatic bit fit_smallest(int t);
		logic [7:0] dem;
		int best;
		dem = demands[8*t +: 8];
		best = -1;
		for (int j = 0; j < 8; j++)
			if (!s_busy[j] && sizes[8*j +: 8] >= dem)
				if (best < 0 || sizes[8*best +: 8] > sizes[8*j +: 8])
					best = j;
		if (best < 0)
			return 0;
		load_slot(best, t);
		t_pri[t] += 32'(dem);
		s_pri[best] = t_pri[t];
		return 1;
	endfunction

	function automatic void preempt(int t);
		logic [7:0] dem;
		logic signed [31:0] np;
		int old;
		dem = demands[8*t +: 8];
		for (int j = 0; j < 8; j++) begin
			np = s_pri[j] - 32'(s_cut[j]);
			if (np > $signed(t_pri[t]) && sizes[8*j +: 8] >= dem) begin
				old = s_task[j];
				if (old < 8)
					t_pri[old] -= 32'(s_cut[j]);
				load_slot(j, t);
				s_pri[j] = t_pri[t];
				t_pri[t] += 32'(dem);
				return;
			end
		end
	endfunction

	function automatic tick_result_t schedule_tick(logic last);
		tick_result_t r;
		logic [15:0] q, tk;
		logic [63:0] total, dev, rate;
		logic [31:0] num;
		bit any_free;
		q  = (quantum == 0) ? 16'd1 : quantum;
		tk = tick_cnt;
		if (shuffle)
			for (int k = 0; k < 8; k++) begin
				seed ^= seed << rsfs_pkg::XS_A;
				seed ^= seed >> rsfs_pkg::XS_B;
				seed ^= seed << rsfs_pkg::XS_C;
				order[k] = seed[2:0];
			end
		if (tk % q == 0) begin
			for (int j = 0; j < 8; j++)
				if (s_busy[j] && s_elap[j] != 0) begin
					s_busy[j] = 0; s_len[j] = 0; s_elap[j] = 0; s_pri[j] = 0; s_cut[j] = 0;
					s_prev[j] = s_task[j];
					s_task[j] = rsfs_pkg::NO_TASK;
				end
			for (int k = 0; k < 8; k++) begin
				any_free = 0;
				for (int j = 0; j < 8; j++)
					if (!s_busy[j]) any_free = 1;
				if (!(any_free && fit_smallest(order[k])))
					preempt(order[k]);
			end
			for (int j = 0; j < 8; j++)
				if (s_busy[j]) s_elap[j]++;
			rate_tick = tk;
			for (int k = 0; k < 8; k++)
				t_snap[k] = t_done[k];
		end else begin
			for (int j = 0; j < 8; j++) begin
				if (!s_busy[j]) continue;
				s_elap[j]++;
				// a zero run length never completes
				if (s_elap[j] != 0 && s_len[j] != 0 && s_elap[j] % s_len[j] == 0)
					if (s_task[j] < 8 && t_done[s_task[j]] != 16'hFFFF)
						t_done[s_task[j]]++;
			end
		end
		total = 0;
		for (int j = 0; j < 8; j++) begin
			if (s_prev[j] != s_task[j]) begin
				if (s_recf[j] != 16'hFFFF) s_recf[j]++;
				s_prev[j] = s_task[j];
			end
			r.occupants[4*j +: 4] = s_task[j];
			total += s_recf[j];
		end
		r.reconfigs = (total > 64'hFFFFF) ? 20'hFFFFF : total[19:0];
		dev = 0;
		if (last) begin
			for (int k = 0; k < 8; k++) begin
				num = 32'(demands[8*k +: 8]) * 32'(latencies[8*k +: 8]) * 32'(t_snap[k]);
				rate = (rate_tick != 0) ? ({16'd0, num, 16'd0} / rate_tick) : 64'd0;
				dev += (rate >= target) ? rate - target : 64'(target) - rate;
			end
			if (dev > 64'(rsfs_pkg::DEV_MAX)) dev = 64'(rsfs_pkg::DEV_MAX);
		end
		r.tick = tk;
		r.done = last;
		r.deviation = dev[26:0];
		tick_cnt = tk + 16'd1;
		if (last)
			clear_sched();
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tick_result_t e;
		if (!arst_n) begin
			sizes = rsfs_pkg::SLOT_SIZES_RST; demands = rsfs_pkg::DEMANDS_RST;
			latencies = rsfs_pkg::LATENCIES_RST;
			quantum = rsfs_pkg::QUANTUM_RST; shuffle = rsfs_pkg::SHUFFLE_RST;
			target = rsfs_pkg::TARGET_RST;
			clear_sched();
			due_q.delete();
			errors = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					rsfs_pkg::CFG_SLOT_SIZES:     sizes     = cfg.data;
					rsfs_pkg::CFG_TASK_DEMANDS:   demands   = cfg.data;
					rsfs_pkg::CFG_TASK_LATENCIES: latencies = cfg.data;
					rsfs_pkg::CFG_QUANTUM:        quantum   = cfg.data[15:0];
					rsfs_pkg::CFG_SHUFFLE_ENABLE: shuffle   = cfg.data[0];
					rsfs_pkg::CFG_TARGET_SHARE:   target    = cfg.data[23:0];
					default: ;
				endcase
			end
			if (res.valid && res.ready) begin
				if (due_q.size() == 0) begin
					$error("result with no request outstanding, tick %0d", res.tick_number);
					errors++;
				end else begin
					e = due_q.pop_front();
					if (res.slot_occupants !== e.occupants) begin
						$error("slot_occupants exp %h got %h", e.occupants, res.slot_occupants);
						errors++;
					end
					if (res.tick_number !== e.tick) begin
						$error("tick_number exp %0d got %0d", e.tick, res.tick_number);
						errors++;
					end
					if (res.reconfig_total !== e.reconfigs) begin
						$error("reconfig_total exp %0d got %0d", e.reconfigs, res.reconfig_total);
						errors++;
					end
					if (res.frame_done !== e.done) begin
						$error("frame_done exp %0b got %0b", e.done, res.frame_done);
						errors++;
					end
					if (res.deviation_sum !== e.deviation) begin
						$error("deviation_sum exp %h got %h", e.deviation, res.deviation_sum);
						errors++;
					end
				end
			end
			if (req.valid && req.ready)
				due_q.push_back(schedule_tick(req.last_tick));
		end
		pending = due_q.size();
	end

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives ticks and register writes into the slot scheduler with random
// gaps and receiver stalls; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   errors, pending;
	int   cycles = 0;
	bit   quiet = 0;      // no idling on either side
	bit   hold_now = 0;   // receiver long hold-off request

	rsfs_req_if req ();
	rsfs_res_if res ();
	rsfs_cfg_if cfg ();

	reconfig_slot_fair_scheduler_top u_dut (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .res(res.source), .cfg(cfg.sink)
	);

	rsfs_tb_checker u_chk (
		.clk(clk), .arst_n(arst_n), .req(req), .res(res), .cfg(cfg),
		.errors(errors), .pending(pending)
	);

	always #5 clk = ~clk;

	// watchdog: ends a run that hangs and reports it as a mismatch
	always @(posedge clk) begin
		cycles++;
		if (cycles > 2_000_000) begin
			$display("reconfig_slot_fair_scheduler_top: mismatch");
			$finish;
		end
	end

	// receiver: random short stalls, one long hold when asked
	initial begin
		res.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_now) begin
				hold_now = 0;
				res.ready <= 1'b0;
				repeat (400) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				res.ready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end else begin
				res.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	task automatic write_reg(rsfs_pkg::cfg_idx_t idx, logic [63:0] d);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= d;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	// drain outstanding requests, then let the sequencer settle
	task automatic drain();
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// one tick request; valid stays up into the next request unless a gap falls
	task automatic send_tick(logic l);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		req.valid     <= 1'b1;
		req.last_tick <= l;
		do @(posedge clk); while (!req.ready);
	endtask

	task automatic send_frame(int n);
		for (int i = 0; i < n; i++)
			send_tick(i == n - 1);
	endtask

	function automatic logic [63:0] rand_bytes(int lo);
		logic [63:0] v;
		for (int b = 0; b < 8; b++)
			v[8*b +: 8] = 8'($urandom_range(lo, 255));
		return v;
	endfunction

	task automatic load_all(logic [63:0] sz, logic [63:0] dm, logic [63:0] lt,
			logic [15:0] q, logic sh, logic [23:0] tg);
		req.valid <= 1'b0;
		drain();
		write_reg(rsfs_pkg::CFG_SLOT_SIZES, sz);
		write_reg(rsfs_pkg::CFG_TASK_DEMANDS, dm);
		write_reg(rsfs_pkg::CFG_TASK_LATENCIES, lt);
		write_reg(rsfs_pkg::CFG_QUANTUM, {48'd0, q});
		write_reg(rsfs_pkg::CFG_SHUFFLE_ENABLE, {63'd0, sh});
		write_reg(rsfs_pkg::CFG_TARGET_SHARE, {40'd0, tg});
	endtask

	initial begin
		int left, n;
		req.valid = 1'b0;
		req.last_tick = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = rsfs_pkg::CFG_SLOT_SIZES;
		cfg.data = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset registers, first tick counts every slot
		send_frame(3);
		// all maxed out, shuffle on, quantum 1
		load_all('1, '1, '1, 16'd1, 1'b1, 24'hFFFFFF);
		send_frame(4);
		// nothing fits anywhere, zero target
		load_all('0, '1, 64'h0101010101010101, 16'hFFFF, 1'b0, 24'd0);
		send_frame(3);
		// mixed fits, preemption between tasks, runs completing
		load_all(64'h10_20_30_40_08_04_02_01, 64'h02_05_30_01_40_10_20_03,
			64'h01_02_03_04_05_06_07_08, 16'd3, 1'b0, 24'h010000);
		send_frame(12);
		// single frame-done on its own right after a frame
		send_frame(1);

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: load_all('1, '1, '1, 16'hFFFF, 1'b1, 24'hFFFFFF);
				1: load_all('0, '0, 64'h0101010101010101, 16'd1, 1'b0, 24'd0);
				default: load_all({$urandom, $urandom}, rand_bytes(0), rand_bytes(1),
					($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 6)),
					1'($urandom), 24'($urandom));
			endcase
			if (ph == 5) quiet = 1;
			left = 130;
			while (left > 0) begin
				n = $urandom_range(3, 40);
				if (n > left) n = left;
				if (ph == 3 && left < 100 && left > 60) begin
					hold_now = 1;       // receiver stops, sender keeps offering
					send_frame(n);
				end else if (ph == 4 && left < 70) begin
					send_frame(n);
					req.valid <= 1'b0;
					drain();            // sender pauses for all results
				end else begin
					send_frame(n);
				end
				left -= n;
			end
		end
		req.valid <= 1'b0;

		drain();
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("reconfig_slot_fair_scheduler_top: match");
		else
			$display("reconfig_slot_fair_scheduler_top: mismatch");
		$finish;
	end

endmodule

`default_nettype wire
